// ===== rtl/bis_pkg.sv =====
package bis_pkg;

    localparam int MAX_WIDTH_DEF = 256;

    localparam int CFG_W    = 9;
    localparam int IDX_W    = 9;
    localparam int BYTE_W   = 8;
    localparam int VAL_W    = 24;
    localparam int COORD_W  = 18;
    localparam int FRAC_W   = 16;
    localparam int SCALED_W = 28;
    localparam int WEIGHT_W = 2 * (FRAC_W + 1) - 1;
    localparam int PROD_W   = VAL_W + WEIGHT_W + 1;
    localparam int SUM_W    = PROD_W + 2;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 24;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(256);
    localparam logic [CFG_W-1:0] WIDTH_MIN   = CFG_W'(2);

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    localparam logic signed [SCALED_W-1:0] ONE_Q16 = SCALED_W'(2 ** FRAC_W);

    typedef struct packed {
        logic              is_write;
        logic              rejected;
        logic [VAL_W-1:0]  wr_value;
        logic [IDX_W-1:0]  row0;
        logic [IDX_W-1:0]  row1;
        logic [IDX_W-1:0]  col0;
        logic [IDX_W-1:0]  col1;
        logic [FRAC_W-1:0] frac_x;
        logic [FRAC_W-1:0] frac_z;
    } bis_entry_t;

    // clamp a scaled Q.16 coordinate to [0, scale] and take the integer part
    function automatic logic [IDX_W-1:0] clamp_index(
        input logic signed [SCALED_W-1:0] v,
        input logic [IDX_W-1:0]           scale
    );
        logic signed [SCALED_W-1:0] top;
        logic [IDX_W-1:0]           idx;
        top = $signed({{(SCALED_W-IDX_W-FRAC_W){1'b0}}, scale, {FRAC_W{1'b0}}});
        if (v < 0)
        begin
            idx = '0;
        end
        else if (v > top)
        begin
            idx = scale;
        end
        else
        begin
            idx = v[FRAC_W+IDX_W-1:FRAC_W];
        end
        return idx;
    endfunction

endpackage

// ===== rtl/bis_front.sv =====
module bis_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [bis_pkg::CFG_W-1:0]           width_eff,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                action,
    input  logic [bis_pkg::BYTE_W-1:0]          row_index,
    input  logic [bis_pkg::BYTE_W-1:0]          column_index,
    input  logic [bis_pkg::VAL_W-1:0]           pixel_value,
    input  logic signed [bis_pkg::COORD_W-1:0]  coord_x,
    input  logic signed [bis_pkg::COORD_W-1:0]  coord_z,
    output logic                                push_valid,
    input  logic                                push_ready,
    output bis_pkg::bis_entry_t                 push_entry
);
    import bis_pkg::*;

    logic                       valid_reg;
    logic                       is_write_reg;
    logic                       rejected_reg;
    logic [BYTE_W-1:0]          row_reg;
    logic [BYTE_W-1:0]          col_reg;
    logic [VAL_W-1:0]           value_reg;
    logic signed [SCALED_W-1:0] xs_reg;
    logic signed [SCALED_W-1:0] zs_reg;
    logic [IDX_W-1:0]           scale_reg;

    logic                       advance;
    logic [IDX_W-1:0]           scale;
    logic                       rejected_next;
    logic signed [SCALED_W-1:0] xs_next;
    logic signed [SCALED_W-1:0] zs_next;
    logic [IDX_W-1:0]           cx0;
    logic [IDX_W-1:0]           cx1;
    logic [IDX_W-1:0]           cz0;
    logic [IDX_W-1:0]           cz1;

    assign advance  = !valid_reg || push_ready;
    assign in_ready = advance;

    assign scale = IDX_W'(width_eff - 1'b1);
    assign rejected_next = (action == ACT_WRITE) &&
                           ((CFG_W'(row_index) >= width_eff) ||
                            (CFG_W'(column_index) >= width_eff));
    assign xs_next = coord_x * $signed({1'b0, scale});
    assign zs_next = coord_z * $signed({1'b0, scale});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            is_write_reg <= (action == ACT_WRITE);
            rejected_reg <= rejected_next;
            row_reg      <= row_index;
            col_reg      <= column_index;
            value_reg    <= pixel_value;
            xs_reg       <= xs_next;
            zs_reg       <= zs_next;
            scale_reg    <= scale;
        end
    end

    assign cx0 = clamp_index(xs_reg, scale_reg);
    assign cx1 = clamp_index(xs_reg + ONE_Q16, scale_reg);
    assign cz0 = clamp_index(zs_reg, scale_reg);
    assign cz1 = clamp_index(zs_reg + ONE_Q16, scale_reg);

    always_comb
    begin
        push_entry.is_write = is_write_reg;
        push_entry.rejected = rejected_reg;
        push_entry.wr_value = value_reg;
        if (is_write_reg)
        begin
            push_entry.row0   = IDX_W'(row_reg);
            push_entry.row1   = IDX_W'(row_reg);
            push_entry.col0   = IDX_W'(col_reg);
            push_entry.col1   = IDX_W'(col_reg);
            push_entry.frac_x = '0;
            push_entry.frac_z = '0;
        end
        else
        begin
            push_entry.row0   = cx0;
            push_entry.row1   = cx1;
            push_entry.col0   = cz0;
            push_entry.col1   = cz1;
            // on an edge the weight of the far neighbor is zero
            push_entry.frac_x = (cx0 == cx1) ? '0 : xs_reg[FRAC_W-1:0];
            push_entry.frac_z = (cz0 == cz1) ? '0 : zs_reg[FRAC_W-1:0];
        end
    end

    assign push_valid = valid_reg;

    a_neighbor_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && !push_entry.is_write) |->
        ((push_entry.row1 == push_entry.row0 || push_entry.row1 == push_entry.row0 + 1'b1) &&
         (push_entry.col1 == push_entry.col0 || push_entry.col1 == push_entry.col0 + 1'b1)))
        else $error("neighbor index not adjacent to cell");

endmodule

// ===== rtl/bis_queue.sv =====
module bis_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  bis_pkg::bis_entry_t push_entry,
    output logic                pop_valid,
    input  logic                pop_ready,
    output bis_pkg::bis_entry_t pop_entry
);
    import bis_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    bis_entry_t       entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != (PTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_entry  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1) &&
                           (wr_ptr_reg == $past(wr_ptr_reg) + 1'b1))
        else $error("queue count out of step with pointers");

endmodule

// ===== rtl/bis_back.sv =====
module bis_back #(
    parameter int MAX_WIDTH = bis_pkg::MAX_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        head_valid,
    output logic                        head_ready,
    input  bis_pkg::bis_entry_t         head,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [bis_pkg::VAL_W-1:0]   out_value,
    output logic                        out_rejected
);
    import bis_pkg::*;

    localparam int IW_RAW     = (MAX_WIDTH > 4) ? $clog2(MAX_WIDTH) : 2;
    localparam int IW         = (IW_RAW > IDX_W) ? IDX_W : IW_RAW;
    localparam int BAW        = 2 * (IW - 1);
    localparam int BANK_DEPTH = 2 ** BAW;
    localparam logic [WEIGHT_W+1:0] WSUM_FULL = (WEIGHT_W+2)'(1) << (2 * FRAC_W);

    logic advance;
    logic pop;

    // stage 1: bank read data and weights
    logic [VAL_W-1:0]    bank_rd [4];
    logic                v1_reg;
    logic                is_write1_reg;
    logic                rejected1_reg;
    logic                px0_reg;
    logic                px1_reg;
    logic                pz0_reg;
    logic                pz1_reg;
    logic [WEIGHT_W-1:0] w_ul_reg;
    logic [WEIGHT_W-1:0] w_ur_reg;
    logic [WEIGHT_W-1:0] w_dl_reg;
    logic [WEIGHT_W-1:0] w_dr_reg;

    // stage 2: weighted products
    logic                     v2_reg;
    logic                     is_write2_reg;
    logic                     rejected2_reg;
    logic signed [PROD_W-1:0] p_ul_reg;
    logic signed [PROD_W-1:0] p_ur_reg;
    logic signed [PROD_W-1:0] p_dl_reg;
    logic signed [PROD_W-1:0] p_dr_reg;

    // output word
    logic             out_valid_reg;
    logic [VAL_W-1:0] out_value_reg;
    logic             out_rejected_reg;

    logic [FRAC_W:0]         gx;
    logic [FRAC_W:0]         gz;
    logic [VAL_W-1:0]        v_ul;
    logic [VAL_W-1:0]        v_ur;
    logic [VAL_W-1:0]        v_dl;
    logic [VAL_W-1:0]        v_dr;
    logic signed [SUM_W-1:0] sum;
    logic [WEIGHT_W+1:0]     wsum;

    assign advance    = !out_valid_reg || out_ready;
    assign pop        = advance && head_valid;
    assign head_ready = advance;

    // four banks by row and column parity; each sees at most one access per item
    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        localparam logic PR = 1'(b >> 1);
        localparam logic PC = 1'(b & 1);

        logic [VAL_W-1:0] mem [BANK_DEPTH];
        logic [VAL_W-1:0] rd_reg;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [BAW-1:0]   addr;
        logic             wr;

        assign row  = (head.row0[0] == PR) ? head.row0 : head.row1;
        assign col  = (head.col0[0] == PC) ? head.col0 : head.col1;
        assign addr = {row[IW-1:1], col[IW-1:1]};
        assign wr   = head.is_write && !head.rejected &&
                      (head.row0[0] == PR) && (head.col0[0] == PC);

        always_ff @(posedge clk)
        begin
            if (pop)
            begin
                if (wr)
                begin
                    mem[addr] <= head.wr_value;
                end
                else
                begin
                    rd_reg <= mem[addr];
                end
            end
        end

        assign bank_rd[b] = rd_reg;
    end

    assign gx = (FRAC_W+1)'(2 ** FRAC_W) - {1'b0, head.frac_x};
    assign gz = (FRAC_W+1)'(2 ** FRAC_W) - {1'b0, head.frac_z};

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            is_write1_reg <= head.is_write;
            rejected1_reg <= head.rejected;
            px0_reg       <= head.row0[0];
            px1_reg       <= head.row1[0];
            pz0_reg       <= head.col0[0];
            pz1_reg       <= head.col1[0];
            w_ul_reg      <= WEIGHT_W'(gx) * WEIGHT_W'(gz);
            w_ur_reg      <= WEIGHT_W'(gx) * WEIGHT_W'(head.frac_z);
            w_dl_reg      <= WEIGHT_W'(head.frac_x) * WEIGHT_W'(gz);
            w_dr_reg      <= WEIGHT_W'(head.frac_x) * WEIGHT_W'(head.frac_z);
        end
    end

    assign v_ul = bank_rd[{px0_reg, pz0_reg}];
    assign v_ur = bank_rd[{px0_reg, pz1_reg}];
    assign v_dl = bank_rd[{px1_reg, pz0_reg}];
    assign v_dr = bank_rd[{px1_reg, pz1_reg}];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            is_write2_reg <= is_write1_reg;
            rejected2_reg <= rejected1_reg;
            p_ul_reg      <= $signed(v_ul) * $signed({1'b0, w_ul_reg});
            p_ur_reg      <= $signed(v_ur) * $signed({1'b0, w_ur_reg});
            p_dl_reg      <= $signed(v_dl) * $signed({1'b0, w_dl_reg});
            p_dr_reg      <= $signed(v_dr) * $signed({1'b0, w_dr_reg});
        end
    end

    // weights sum to 2^32, so the floor is a plain arithmetic shift
    assign sum = SUM_W'(p_ul_reg) + SUM_W'(p_ur_reg) + SUM_W'(p_dl_reg) + SUM_W'(p_dr_reg);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_value_reg    <= is_write2_reg ? '0 : sum[2*FRAC_W+VAL_W-1:2*FRAC_W];
            out_rejected_reg <= is_write2_reg && rejected2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg        <= pop;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_value    = out_value_reg;
    assign out_rejected = out_rejected_reg;

    assign wsum = (WEIGHT_W+2)'(w_ul_reg) + (WEIGHT_W+2)'(w_ur_reg) +
                  (WEIGHT_W+2)'(w_dl_reg) + (WEIGHT_W+2)'(w_dr_reg);

    a_weights_unity: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> (wsum == WSUM_FULL))
        else $error("blend weights do not sum to one");

    // write words may carry unknown products, so compare case-equal
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !advance) |=> v2_reg && (p_ul_reg === $past(p_ul_reg)) &&
                                 (p_dr_reg === $past(p_dr_reg)))
        else $error("product stage changed while stalled");

    a_reject_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_rejected_reg) |-> (out_value_reg == '0))
        else $error("rejected write carries a value");

endmodule

// ===== rtl/bilinear_image_sampler.sv =====
// Bilinear height-image sampler with clamp-to-edge addressing.
// Slave stream s_*: one word per item; s_tuser selects write (0) or sample (1).
// A write stores pixel_value at (row_index, column_index); a sample blends the
// four stored samples around (coord_x, coord_z) scaled by the width in use - 1.
// Master stream m_*: one word per item, in order; m_tuser flags a write whose
// index is at or beyond the width in use (nothing is stored, data is zero).
// cfg_we/cfg_wdata set image_width; write it only while no item is in flight.
// The result word passes the front register, queue, bank read, product stage
// and output register, in that order, before it shows on m_tvalid.
// Throughput: one item per cycle while m_tready stays high; four single-port banks split
// by row and column parity serve the four corner reads of a sample in one access.
// A stalled m_tready backs up the output, product and bank read stages; the 4-deep
// queue and the front register keep taking words until full, then s_tready drops.
// Reset clears control state and sets image_width to 256; the image store is
// not cleared and holds nothing meaningful until written.
module bilinear_image_sampler #(
    parameter int MAX_WIDTH = bis_pkg::MAX_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [bis_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // row_index[7:0], column_index[15:8], pixel_value[39:16],
    // coord_x[57:40], coord_z[75:58], zero pad[79:76]
    input  logic [bis_pkg::IN_DATA_W-1:0]     s_tdata,
    // action[0]
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // sample_value[23:0]
    output logic [bis_pkg::OUT_DATA_W-1:0]    m_tdata,
    // write_rejected[0]
    output logic                              m_tuser
);
    import bis_pkg::*;

    localparam logic [CFG_W-1:0] WIDTH_MAX = CFG_W'((MAX_WIDTH > 511) ? 511 : MAX_WIDTH);

    logic [CFG_W-1:0] image_width_reg;
    logic [CFG_W-1:0] width_eff;

    bis_entry_t push_entry;
    bis_entry_t head_entry;
    logic       push_valid;
    logic       push_ready;
    logic       head_valid;
    logic       head_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            image_width_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        if (image_width_reg < WIDTH_MIN)
        begin
            width_eff = WIDTH_MIN;
        end
        else if (image_width_reg > WIDTH_MAX)
        begin
            width_eff = WIDTH_MAX;
        end
        else
        begin
            width_eff = image_width_reg;
        end
    end

    bis_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .width_eff    (width_eff),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .action       (s_tuser),
        .row_index    (s_tdata[7:0]),
        .column_index (s_tdata[15:8]),
        .pixel_value  (s_tdata[39:16]),
        .coord_x      ($signed(s_tdata[57:40])),
        .coord_z      ($signed(s_tdata[75:58])),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_entry   (push_entry)
    );

    bis_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (head_valid),
        .pop_ready  (head_ready),
        .pop_entry  (head_entry)
    );

    bis_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_ready   (head_ready),
        .head         (head_entry),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_value    (m_tdata),
        .out_rejected (m_tuser)
    );

endmodule
